[rtl/tlg_pkg.sv]
`default_nettype none
package tlg_pkg;

    localparam int unsigned TS_W     = 64;
    localparam int unsigned PERIOD_W = 32;
    localparam int unsigned COUNT_W  = 24;
    localparam int unsigned GRAV_W   = 32;
    localparam int unsigned LAT_W    = 32;
    localparam int unsigned SUM_W    = 64;
    localparam int unsigned ROUND_W  = 5;
    localparam int unsigned STABLE_W = 2;
    localparam int unsigned CFG_W    = 32;

    localparam logic [ROUND_W-1:0]  MAX_ROUNDS    = 5'd30;
    localparam logic [STABLE_W-1:0] STABLE_NEEDED = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t ST_IDLE      = 2'd0;
    localparam status_t ST_MEASURING = 2'd1;
    localparam status_t ST_CONVERGED = 2'd2;
    localparam status_t ST_GAVE_UP   = 2'd3;

    typedef logic opcode_t;
    localparam opcode_t OP_BEGIN  = 1'b0;
    localparam opcode_t OP_EXPIRY = 1'b1;

    typedef logic cfg_index_t;
    localparam cfg_index_t CFG_PERIOD  = 1'b0;
    localparam cfg_index_t CFG_SAMPLES = 1'b1;

    localparam logic signed [LAT_W-1:0] LAT_MAX_VAL = 32'sh7FFF_FFFF;
    localparam logic signed [LAT_W-1:0] LAT_MIN_VAL = 32'sh8000_0000;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 32'd1000;
    localparam logic [COUNT_W-1:0]  SAMPLES_RESET = 24'd10000;

endpackage
`default_nettype wire

[rtl/tlg_if.sv]
`default_nettype none
interface tlg_event_if
    import tlg_pkg::*;
();
    logic              valid;
    logic              ready;
    opcode_t           opcode;
    logic [TS_W-1:0]   timestamp;

    modport source (output valid, opcode, timestamp, input ready);
    modport sink   (input valid, opcode, timestamp, output ready);
endinterface

interface tlg_result_if
    import tlg_pkg::*;
();
    logic                     valid;
    logic                     ready;
    status_t                  status;
    logic                     round_end;
    logic [GRAV_W-1:0]        gravity_ticks;
    logic [ROUND_W-1:0]       round_index;
    logic signed [LAT_W-1:0]  round_min;
    logic signed [LAT_W-1:0]  round_max;
    logic signed [SUM_W-1:0]  round_sum;

    modport source (output valid, status, round_end, gravity_ticks, round_index,
                    round_min, round_max, round_sum, input ready);
    modport sink   (input valid, status, round_end, gravity_ticks, round_index,
                    round_min, round_max, round_sum, output ready);
endinterface
`default_nettype wire

[rtl/timer_latency_gravity_tuner.sv]
// Timer latency gravity tuner. Takes requests (begin or timer expiry with a
// 64-bit timestamp) and returns one result per request. A request is
// captured in an input register; the whole latency measurement and gravity
// update is combinational into the result register, which loads once the
// result side can take it. The block sustains one request per cycle while
// the result side does not stall, as the update loop on the tuning state
// (expected expiry, round statistics, gravity) is combinational. The result
// register lets a new request in while a finished result waits; when the
// result side stalls, requests back up into the input register. Configuration
// (period, samples per round) is written by index; the user must write it
// only while no request is in flight, and the block does not enforce that.
`default_nettype none
module timer_latency_gravity_tuner
    import tlg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire cfg_index_t  cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    tlg_event_if.sink        events,
    tlg_result_if.source     results
);

    // configuration
    logic [PERIOD_W-1:0] period_reg;
    logic [COUNT_W-1:0]  samples_reg;

    // input register
    logic             in_vld_reg;
    opcode_t          in_op_reg;
    logic [TS_W-1:0]  in_ts_reg;

    // tuning state
    logic [TS_W-1:0]          exp_reg, exp_next;
    logic signed [LAT_W-1:0]  min_reg, min_next;
    logic signed [LAT_W-1:0]  max_reg, max_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [COUNT_W-1:0]       cnt_reg, cnt_next;
    logic [GRAV_W-1:0]        grav_reg, grav_next;
    logic [GRAV_W-1:0]        pgrav_reg, pgrav_next;
    logic signed [LAT_W-1:0]  pmin_reg, pmin_next;
    logic [STABLE_W-1:0]      stable_reg, stable_next;
    logic [ROUND_W-1:0]       round_reg, round_next;
    status_t                  status_reg, status_next;

    // result register
    logic                     out_vld_reg;
    status_t                  r_status_reg;
    logic                     r_end_reg;
    logic [GRAV_W-1:0]        r_grav_reg;
    logic [ROUND_W-1:0]       r_round_reg;
    logic signed [LAT_W-1:0]  r_min_reg;
    logic signed [LAT_W-1:0]  r_max_reg;
    logic signed [SUM_W-1:0]  r_sum_reg;

    logic                     advance;
    logic                     proc;
    logic                     ended;
    logic [ROUND_W-1:0]       shown_round;

    // datapath temporaries
    logic [TS_W-1:0]          diff;
    logic signed [LAT_W-1:0]  lat;
    logic signed [LAT_W-1:0]  base_min;
    logic signed [LAT_W-1:0]  base_max;
    logic signed [SUM_W-1:0]  base_sum;
    logic [COUNT_W-1:0]       cnt_inc;
    logic signed [LAT_W-1:0]  mn;
    logic signed [LAT_W-1:0]  mn_bias;
    logic signed [LAT_W-1:0]  half;
    logic signed [LAT_W-1:0]  adj;
    logic [STABLE_W-1:0]      stable_inc;
    logic signed [GRAV_W+1:0] g;
    logic [TS_W-1:0]          ts_plus_period;

    assign advance        = !out_vld_reg || results.ready;
    assign proc           = in_vld_reg && advance;
    assign events.ready   = !in_vld_reg || advance;
    assign ts_plus_period = in_ts_reg + {{(TS_W-PERIOD_W){1'b0}}, period_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= PERIOD_RESET;
            samples_reg <= SAMPLES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PERIOD:  period_reg  <= cfg_data[PERIOD_W-1:0];
                CFG_SAMPLES: samples_reg <= cfg_data[COUNT_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (events.valid && events.ready)
            in_vld_reg <= 1'b1;
        else if (advance)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (events.valid && events.ready)
        begin
            in_op_reg <= events.opcode;
            in_ts_reg <= events.timestamp;
        end
    end

    always_comb
    begin
        exp_next    = exp_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        grav_next   = grav_reg;
        pgrav_next  = pgrav_reg;
        pmin_next   = pmin_reg;
        stable_next = stable_reg;
        round_next  = round_reg;
        status_next = status_reg;
        ended       = 1'b0;
        shown_round = round_reg;

        // saturate the 64-bit latency to signed 32 bits
        diff = in_ts_reg - exp_reg;
        if (diff[TS_W-1:LAT_W-1] == '0 || diff[TS_W-1:LAT_W-1] == '1)
            lat = diff[LAT_W-1:0];
        else if (diff[TS_W-1])
            lat = LAT_MIN_VAL;
        else
            lat = LAT_MAX_VAL;

        if (cnt_reg == '0)
        begin
            base_min = LAT_MAX_VAL;
            base_max = '0;
            base_sum = '0;
        end
        else
        begin
            base_min = min_reg;
            base_max = max_reg;
            base_sum = sum_reg;
        end
        cnt_inc = cnt_reg + 1'b1;
        mn      = (lat < base_min) ? lat : base_min;

        // halve toward zero
        mn_bias    = mn + {{(LAT_W-1){1'b0}}, mn[LAT_W-1]};
        half       = mn_bias >>> 1;
        adj        = (half == '0 && mn < 0) ? mn : half;
        stable_inc = stable_reg + 1'b1;
        g          = $signed({2'b00, grav_reg}) + {{2{adj[LAT_W-1]}}, adj};

        if (proc)
        begin
            if (in_op_reg == OP_BEGIN)
            begin
                grav_next   = '0;
                pgrav_next  = '0;
                pmin_next   = '0;
                stable_next = '0;
                round_next  = ROUND_W'(1);
                shown_round = ROUND_W'(1);
                exp_next    = ts_plus_period;
                min_next    = LAT_MAX_VAL;
                max_next    = '0;
                sum_next    = '0;
                cnt_next    = '0;
                status_next = ST_MEASURING;
            end
            else if (status_reg == ST_MEASURING)
            begin
                min_next = mn;
                max_next = (lat > base_max) ? lat : base_max;
                sum_next = base_sum + {{(SUM_W-LAT_W){lat[LAT_W-1]}}, lat};
                exp_next = exp_reg + {{(TS_W-PERIOD_W){1'b0}}, period_reg};
                cnt_next = cnt_inc;
                if (cnt_inc >= samples_reg)
                begin
                    ended    = 1'b1;
                    cnt_next = '0;
                end

                if (ended)
                begin
                    if (round_reg > ROUND_W'(1) && mn < 0 && pmin_reg > 0)
                    begin
                        // sign flipped to negative: roll back
                        grav_next   = pgrav_reg;
                        status_next = ST_CONVERGED;
                    end
                    else if (round_reg > ROUND_W'(1) && mn > 0 && pmin_reg < 0)
                    begin
                        status_next = ST_CONVERGED;
                    end
                    else if (half == '0 && stable_inc == STABLE_NEEDED)
                    begin
                        stable_next = stable_inc;
                        status_next = ST_CONVERGED;
                    end
                    else
                    begin
                        stable_next = (half == '0) ? stable_inc : '0;
                        pgrav_next  = grav_reg;
                        pmin_next   = mn;
                        // drop a decrease below zero, clamp an increase
                        if (!g[GRAV_W+1])
                            grav_next = g[GRAV_W] ? '1 : g[GRAV_W-1:0];
                        if (round_reg >= MAX_ROUNDS)
                            status_next = ST_GAVE_UP;
                        else
                        begin
                            round_next = round_reg + 1'b1;
                            exp_next   = ts_plus_period;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg    <= '0;
            min_reg    <= LAT_MAX_VAL;
            max_reg    <= '0;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            grav_reg   <= '0;
            pgrav_reg  <= '0;
            pmin_reg   <= '0;
            stable_reg <= '0;
            round_reg  <= '0;
            status_reg <= ST_IDLE;
        end
        else
        begin
            exp_reg    <= exp_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
            grav_reg   <= grav_next;
            pgrav_reg  <= pgrav_next;
            pmin_reg   <= pmin_next;
            stable_reg <= stable_next;
            round_reg  <= round_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (proc)
            out_vld_reg <= 1'b1;
        else if (results.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            r_status_reg <= status_next;
            r_end_reg    <= ended;
            r_grav_reg   <= grav_next;
            r_round_reg  <= shown_round;
            r_min_reg    <= min_next;
            r_max_reg    <= max_next;
            r_sum_reg    <= sum_next;
        end
    end

    assign results.valid         = out_vld_reg;
    assign results.status        = r_status_reg;
    assign results.round_end     = r_end_reg;
    assign results.gravity_ticks = r_grav_reg;
    assign results.round_index   = r_round_reg;
    assign results.round_min     = r_min_reg;
    assign results.round_max     = r_max_reg;
    assign results.round_sum     = r_sum_reg;

    a_round_limit: assert property (@(posedge clk) disable iff (!rst_n)
        round_reg <= MAX_ROUNDS)
        else $error("round counter past limit");

    a_begin_result: assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_op_reg == OP_BEGIN |=>
            out_vld_reg && r_status_reg == ST_MEASURING && r_round_reg == ROUND_W'(1)
            && !r_end_reg)
        else $error("begin request gave wrong result");

    a_end_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && r_end_reg |-> r_status_reg != ST_IDLE)
        else $error("round closed while idle");

    a_held_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !advance |=> in_vld_reg && $stable(in_ts_reg) && $stable(in_op_reg))
        else $error("held request lost");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !results.ready |=> out_vld_reg && $stable(r_sum_reg))
        else $error("stalled result changed");

endmodule
`default_nettype wire
